FILE: hw/rtl/largest_square_of_ones_assert.svh
// Assertion macros used by the checker of the largest-square block.
`ifndef LARGEST_SQUARE_OF_ONES_ASSERT_SVH
`define LARGEST_SQUARE_OF_ONES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lsq_pkg.sv
// Package with the widths, limits and reset values of the largest-square block.
package lsq_pkg;

  localparam int VALUE_W         = 11;
  localparam int INDEX_W         = 10;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 32;
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 1024;

  localparam logic [VALUE_W-1:0] COLUMNS_RESET = 11'd1024;
  localparam logic [VALUE_W-1:0] VALUE_MAX     = 11'h7FF;

endpackage

FILE: hw/rtl/largest_square_of_ones.sv
// Top level of the largest-square-of-ones finder with its one-row line buffer.
//
// The block scans a binary grid that arrives in row-major order, one cell per input
// transaction, with in_tlast on the final cell. It accepts one cell per clock cycle
// for as long as the input keeps coming. When a cell is accepted, the line buffer
// (one synchronous memory of MAX_COLUMNS entries, one read and one write port) is
// read for the value above and the cell moves into the second stage; when it leaves
// the second stage the three-way minimum is formed, the new value is written back
// and the running best is updated. The single result transaction (row, column and
// side of the first strictly largest square) is loaded into the output register as
// the last cell leaves the second stage, which raises out_tvalid. Input is held
// off only while a last cell waits for an output transaction that has not yet been
// taken. The register written through cfg_wr_en sets the row length; 0 acts as 1
// and values above MAX_COLUMNS act as MAX_COLUMNS, and it should only be changed
// while no grid is in flight. The line buffer needs no clearing after reset, since
// the first row of a grid never uses it.
module largest_square_of_ones #(
  parameter int MAX_COLUMNS = lsq_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lsq_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: the row length in cells.
  input  logic                             cfg_wr_en,
  input  logic [lsq_pkg::VALUE_W-1:0]      cfg_wr_data,
  // Input stream. in_tdata: bit 0 cell_req, bits 7:1 zero.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lsq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  // Result stream. out_tdata: best_row [9:0], best_col [19:10], best_size [30:20],
  // bit 31 zero.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lsq_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int VW    = lsq_pkg::VALUE_W;
  localparam int IW    = lsq_pkg::INDEX_W;

  // Configuration register and effective row length.
  logic [VW-1:0] columns_r;
  logic [31:0]   eff_cols;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= lsq_pkg::COLUMNS_RESET;
    end else if (cfg_wr_en) begin
      columns_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (columns_r == '0) begin
      eff_cols = 32'd1;
    end else if (32'(columns_r) > 32'(MAX_COLUMNS)) begin
      eff_cols = 32'(MAX_COLUMNS);
    end else begin
      eff_cols = 32'(columns_r);
    end
  end

  // Position counters, advanced as each cell is accepted.
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic             accept;

  // Second stage: the cell whose upper neighbor is being read.
  logic             s1_valid_r;
  logic             s1_cell_r;
  logic             s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_fire;

  // Line buffer and its read port.
  logic [VW-1:0] line_mem [MAX_COLUMNS];
  logic [VW-1:0] rd_data_r;
  logic          fwd_r;
  logic [VW-1:0] fwd_data_r;

  // Neighbor values carried along the row.
  logic [VW-1:0] left_r;
  logic [VW-1:0] diag_r;

  // Running best.
  logic [VW-1:0]    best_size_r;
  logic [ROW_W-1:0] best_row_r;
  logic [COL_W-1:0] best_col_r;

  // Output register.
  logic          out_valid_r;
  logic [IW-1:0] out_row_r;
  logic [IW-1:0] out_col_r;
  logic [VW-1:0] out_size_r;

  // A last cell may only leave the second stage when the output register is free
  // or being emptied in this cycle.
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      priority if (in_tlast) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end else if (32'(col_cnt_r) + 32'd1 >= eff_cols) begin
        col_cnt_nxt = '0;
        if (32'(row_cnt_r) + 32'd1 < 32'(MAX_ROWS)) begin
          row_cnt_nxt = row_cnt_r + ROW_W'(1);
        end
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload; loaded only on acceptance so it holds while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell_r <= in_tdata[0];
      s1_last_r <= in_tlast;
      s1_col_r  <= col_cnt_r;
      s1_row_r  <= row_cnt_r;
    end
  end

  // Value computation for the cell in the second stage.
  logic [VW-1:0] upper, left_v, diag_v, min_lu, min_all, entry;
  logic [VW:0]   sum;

  always_comb begin
    if (s1_row_r == '0) begin
      upper = '0;
    end else if (fwd_r) begin
      upper = fwd_data_r;
    end else begin
      upper = rd_data_r;
    end
    left_v  = (s1_col_r == '0) ? '0 : left_r;
    diag_v  = (s1_col_r == '0 || s1_row_r == '0) ? '0 : diag_r;
    min_lu  = (left_v < upper) ? left_v : upper;
    min_all = (diag_v < min_lu) ? diag_v : min_lu;
    sum     = {1'b0, min_all} + (VW+1)'(1);
    if (!s1_cell_r) begin
      entry = '0;
    end else if (sum[VW]) begin
      entry = lsq_pkg::VALUE_MAX;
    end else begin
      entry = sum[VW-1:0];
    end
  end

  // Line buffer: read for the accepted cell, write back the finished one. When the
  // cell being finished sits in the column just being read (a one-column grid), the
  // read returns the old entry, so the new value is captured for forwarding.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_col_r] <= entry;
    end
    if (accept) begin
      rd_data_r  <= line_mem[col_cnt_r];
      fwd_r      <= s1_valid_r && (s1_col_r == col_cnt_r);
      fwd_data_r <= entry;
    end
  end

  // Best tracking; the first strictly larger value wins.
  logic             better;
  logic [VW-1:0]    nb_size;
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  logic [31:0]      nb_row_wide, nb_col_wide;

  always_comb begin
    better      = entry > best_size_r;
    nb_size     = better ? entry : best_size_r;
    nb_row      = better ? s1_row_r : best_row_r;
    nb_col      = better ? s1_col_r : best_col_r;
    nb_row_wide = 32'(nb_row);
    nb_col_wide = 32'(nb_col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_fire) begin
      left_r <= entry;
      diag_r <= upper;
      if (s1_last_r) begin
        left_r      <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        best_size_r <= nb_size;
        best_row_r  <= nb_row;
        best_col_r  <= nb_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_row_r  <= nb_row_wide[IW-1:0];
      out_col_r  <= nb_col_wide[IW-1:0];
      out_size_r <= nb_size;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_size_r, out_col_r, out_row_r};

endmodule

FILE: hw/rtl/lsq_checker.sv
// Port-level checker for the largest-square block, bound to its top level.
`include "largest_square_of_ones_assert.svh"

module lsq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic [lsq_pkg::VALUE_W-1:0]      cfg_wr_data,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [lsq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lsq_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic in_last_acc;
  logic unused_ok;

  assign in_last_acc = in_tvalid && in_tready && in_tlast;
  assign unused_ok   = cfg_wr_en ^ (^cfg_wr_data) ^ (^in_tdata);

  // A pending result holds until it is taken.
  `LSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed or dropped while stalled")

  // A new result rises only after the transaction that carried the last cell.
  `LSQ_ASSERT_SAME(a_out_after_last, clk, rst_n, $rose(out_tvalid),
    $past(in_last_acc, 2), "result without a preceding last cell")

  // Without any square the position stays at the origin.
  `LSQ_ASSERT_SAME(a_empty_origin, clk, rst_n,
    out_tvalid && out_tdata[30:20] == '0,
    out_tdata[19:0] == '0 && !out_tdata[31], "empty result with a nonzero position")

  // The input is only held off while a result is waiting.
  `LSQ_ASSERT_SAME(a_ready_when_idle, clk, rst_n, !in_tready,
    out_tvalid && !out_tready && !unused_ok || out_tvalid && !out_tready,
    "input stalled with the output free")

endmodule

bind largest_square_of_ones lsq_checker u_lsq_checker (.*);
